// ===== hdl/pfa_pkg.sv =====
`default_nettype none

package pfa_pkg;

   localparam int MAX_PARTITIONS_DEF = 16;
   localparam int SIZE_BITS_DEF      = 16;

   // port widths
   localparam int CMD_W       = 2;
   localparam int IDX_PORT_W  = 4;
   localparam int SIZE_PORT_W = 16;
   localparam int CSR_DATA_W  = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int MODE_W      = 2;

   // commands
   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   // placement policies
   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FIT_MODE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PART_COUNT = 1'b1;

   localparam logic [MODE_W-1:0]     FIT_MODE_RESET   = MODE_FIRST;
   localparam logic [CSR_DATA_W-1:0] PART_COUNT_RESET = 5'd16;

endpackage

`default_nettype wire

// ===== hdl/partition_fit_allocator_core.sv =====
`default_nettype none

// Fixed-partition allocator with first, best and next fit placement.
// Channels: req_* carries a command (load, allocate, restart) with a
// partition index and a size; rsp_* returns one result per allocate
// (granted flag, partition index, full partition capacity). csr_* writes
// fit_mode (index 0) and partition_count (index 1), always ready; write
// only while the block is idle.
// With n = partition_count capped at MAX_PARTITIONS, an allocate scans up
// to n partitions; best fit scans them all, a first or next fit hit ends
// the scan at the partition that fits. The table sits in a single memory
// with one registered read port, scanned one partition per cycle through
// one shared subtract/compare unit. Restart rewrites every entry (space
// left = capacity) in a sweep.
// Throughput: loads are taken back to back; the next request is taken
// once an allocate's result registers, or once a restart's sweep ends.
// Reset clears used flags, next-fit pointer, registers and the result
// valid; the capacity table is undefined until loaded. A stalled rsp_ready
// holds the result; a new request is still taken, and the next allocate
// waits at its end until the output register frees up.
module partition_fit_allocator_core #(
   parameter int MAX_PARTITIONS = pfa_pkg::MAX_PARTITIONS_DEF,
   parameter int SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [pfa_pkg::CMD_W-1:0]         req_command,
   input  wire logic [pfa_pkg::IDX_PORT_W-1:0]    req_part_index,
   input  wire logic [pfa_pkg::SIZE_PORT_W-1:0]   req_size_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_granted,
   output logic      [pfa_pkg::IDX_PORT_W-1:0]    rsp_granted_index,
   output logic      [pfa_pkg::SIZE_PORT_W-1:0]   rsp_granted_capacity,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pfa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pfa_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int IDX_W  = $clog2(MAX_PARTITIONS);
   localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);
   localparam int CDW    = pfa_pkg::CSR_DATA_W;
   localparam int CMP_W  = (CNT_W > CDW) ? CNT_W : CDW;
   localparam int PIW    = pfa_pkg::IDX_PORT_W;
   localparam int PI_W   = (CNT_W > PIW) ? CNT_W : PIW;
   localparam int OSW    = pfa_pkg::SIZE_PORT_W;
   localparam int MODE_W = pfa_pkg::MODE_W;
   localparam int WORD_W = 2 * SIZE_BITS;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SWEEP, ST_RESP} state_type;

   state_type                  state_ff, state_in;
   logic [MODE_W-1:0]          fit_mode_ff, fit_mode_in;
   logic [CDW-1:0]             part_count_ff, part_count_in;
   logic [MAX_PARTITIONS-1:0]  used_ff, used_in;
   logic [IDX_W-1:0]           last_ff, last_in;
   logic                       last_vld_ff, last_vld_in;
   logic [CNT_W-1:0]           n_ff, n_in;
   logic [CNT_W-1:0]           k_ff, k_in;
   logic [IDX_W-1:0]           j_ff, j_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]           rd_idx_ff, rd_idx_in;
   logic [SIZE_BITS-1:0]       req_size_ff, req_size_in;
   logic                       found_ff, found_in;
   logic [IDX_W-1:0]           best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0]       best_cap_ff, best_cap_in;
   logic [SIZE_BITS-1:0]       best_left_ff, best_left_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_granted_ff, rsp_granted_in;
   logic [PIW-1:0]             rsp_idx_ff, rsp_idx_in;
   logic [OSW-1:0]             rsp_cap_ff, rsp_cap_in;

   logic                       mem_we;
   logic [IDX_W-1:0]           mem_waddr;
   logic [WORD_W-1:0]          mem_wdata;
   logic [WORD_W-1:0]          mem_rdata;
   logic [SIZE_BITS-1:0]       rd_cap, rd_rem;
   logic [SIZE_BITS-1:0]       unit_a, unit_diff;
   logic                       unit_ge;

   logic                       mode_best, mode_next;
   logic [CNT_W-1:0]           sat_n;
   logic [CNT_W:0]             start_w;
   logic [IDX_W-1:0]           next_start;
   logic [CNT_W-1:0]           j_inc;
   logic                       carve_hit, best_take, issue;
   logic [SIZE_BITS-1:0]       size_in;
   logic                       load_ok;

   pfa_mem #(
      .DEPTH (MAX_PARTITIONS),
      .WIDTH (WORD_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (j_ff),
      .rd_data (mem_rdata)
   );

   pfa_sub #(
      .WIDTH (SIZE_BITS)
   ) u_sub (
      .a    (unit_a),
      .b    (req_size_ff),
      .ge   (unit_ge),
      .diff (unit_diff)
   );

   assign rd_cap    = mem_rdata[WORD_W-1:SIZE_BITS];
   assign rd_rem    = mem_rdata[SIZE_BITS-1:0];
   assign mode_best = (fit_mode_ff == pfa_pkg::MODE_BEST);
   assign mode_next = (fit_mode_ff == pfa_pkg::MODE_NEXT);
   assign unit_a    = mode_best ? rd_cap : rd_rem;

   assign sat_n = (CMP_W'(part_count_ff) > CMP_W'(MAX_PARTITIONS)) ?
                  CNT_W'(MAX_PARTITIONS) : CNT_W'(part_count_ff);
   assign start_w = (CNT_W+1)'(last_ff) + (CNT_W+1)'(1);
   assign next_start = (!last_vld_ff || start_w >= (CNT_W+1)'(sat_n)) ?
                       '0 : IDX_W'(start_w);

   assign j_inc   = CNT_W'(j_ff) + CNT_W'(1);
   assign size_in = SIZE_BITS'(req_size_value);
   assign load_ok = (PI_W'(req_part_index) < PI_W'(MAX_PARTITIONS));

   // carve policies stop at the first fit; best fit runs the whole range
   assign carve_hit = !mode_best && rd_vld_ff && unit_ge;
   assign best_take = mode_best && rd_vld_ff && unit_ge && !used_ff[rd_idx_ff] &&
                      (!found_ff || unit_diff < best_left_ff);

   always_comb begin
      state_in       = state_ff;
      fit_mode_in    = fit_mode_ff;
      part_count_in  = part_count_ff;
      used_in        = used_ff;
      last_in        = last_ff;
      last_vld_in    = last_vld_ff;
      n_in           = n_ff;
      k_in           = k_ff;
      j_in           = j_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = j_ff;
      req_size_in    = req_size_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_cap_in    = best_cap_ff;
      best_left_in   = best_left_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_cap_in     = rsp_cap_ff;
      mem_we         = 1'b0;
      mem_waddr      = rd_idx_ff;
      mem_wdata      = {rd_cap, rd_cap};
      issue          = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            pfa_pkg::REG_FIT_MODE:   fit_mode_in   = csr_data[MODE_W-1:0];
            pfa_pkg::REG_PART_COUNT: part_count_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  pfa_pkg::CMD_LOAD: begin
                     if (load_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = IDX_W'(req_part_index);
                        mem_wdata = {size_in, size_in};
                        used_in[IDX_W'(req_part_index)] = 1'b0;
                     end
                  end
                  pfa_pkg::CMD_ALLOC: begin
                     n_in        = sat_n;
                     k_in        = '0;
                     j_in        = mode_next ? next_start : '0;
                     found_in    = 1'b0;
                     req_size_in = size_in;
                     state_in    = ST_SCAN;
                  end
                  pfa_pkg::CMD_RESTART: begin
                     used_in     = '0;
                     last_in     = '0;
                     last_vld_in = 1'b0;
                     k_in        = '0;
                     j_in        = '0;
                     state_in    = ST_SWEEP;
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            if (carve_hit) begin
               mem_we      = 1'b1;
               mem_waddr   = rd_idx_ff;
               mem_wdata   = {rd_cap, unit_diff};
               found_in    = 1'b1;
               best_idx_in = rd_idx_ff;
               best_cap_in = rd_cap;
               if (mode_next) begin
                  last_in     = rd_idx_ff;
                  last_vld_in = 1'b1;
               end
               state_in = ST_RESP;
            end else begin
               if (best_take) begin
                  found_in     = 1'b1;
                  best_idx_in  = rd_idx_ff;
                  best_cap_in  = rd_cap;
                  best_left_in = unit_diff;
               end
               issue     = (k_ff < n_ff);
               rd_vld_in = issue;
               if (issue) begin
                  k_in = CNT_W'(k_ff + CNT_W'(1));
                  j_in = (j_inc == n_ff) ? '0 : IDX_W'(j_inc);
               end else if (!rd_vld_ff) begin
                  if (mode_best && found_ff) begin
                     used_in[best_idx_ff] = 1'b1;
                  end
                  state_in = ST_RESP;
               end
            end
         end

         ST_SWEEP: begin
            // read entry j, write it back in the next cycle with space = capacity
            mem_we    = rd_vld_ff;
            issue     = (k_ff < CNT_W'(MAX_PARTITIONS));
            rd_vld_in = issue;
            if (issue) begin
               k_in = CNT_W'(k_ff + CNT_W'(1));
               j_in = IDX_W'(j_inc);
            end else if (!rd_vld_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = found_ff;
               rsp_idx_in     = found_ff ? PIW'(best_idx_ff) : '0;
               rsp_cap_in     = found_ff ? OSW'(best_cap_ff) : '0;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fit_mode_ff   <= pfa_pkg::FIT_MODE_RESET;
         part_count_ff <= pfa_pkg::PART_COUNT_RESET;
         used_ff       <= '0;
         last_ff       <= '0;
         last_vld_ff   <= 1'b0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fit_mode_ff    <= fit_mode_in;
         part_count_ff  <= part_count_in;
         used_ff        <= used_in;
         last_ff        <= last_in;
         last_vld_ff    <= last_vld_in;
         n_ff           <= n_in;
         k_ff           <= k_in;
         j_ff           <= j_in;
         rd_vld_ff      <= rd_vld_in;
         rd_idx_ff      <= rd_idx_in;
         req_size_ff    <= req_size_in;
         found_ff       <= found_in;
         best_idx_ff    <= best_idx_in;
         best_cap_ff    <= best_cap_in;
         best_left_ff   <= best_left_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_granted_ff <= rsp_granted_in;
         rsp_idx_ff     <= rsp_idx_in;
         rsp_cap_ff     <= rsp_cap_in;
      end
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_granted          = rsp_granted_ff;
   assign rsp_granted_index    = rsp_idx_ff;
   assign rsp_granted_capacity = rsp_cap_ff;

endmodule

`default_nettype wire

// ===== hdl/pfa_mem.sv =====
`default_nettype none

module pfa_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/pfa_sub.sv =====
`default_nettype none

// Shared subtract/compare: diff = a - b, ge when a >= b.
module pfa_sub #(
   parameter int WIDTH = 16
) (
   input  wire logic [WIDTH-1:0] a,
   input  wire logic [WIDTH-1:0] b,
   output logic                  ge,
   output logic      [WIDTH-1:0] diff
);

   logic [WIDTH:0] full;

   assign full = {1'b0, a} - {1'b0, b};
   assign ge   = ~full[WIDTH];
   assign diff = full[WIDTH-1:0];

endmodule

`default_nettype wire

// ===== hdl/pfa_check.sv =====
`default_nettype none

module pfa_check (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [pfa_pkg::CMD_W-1:0]         req_command,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_granted,
   input wire logic [pfa_pkg::IDX_PORT_W-1:0]    rsp_granted_index,
   input wire logic [pfa_pkg::SIZE_PORT_W-1:0]   rsp_granted_capacity
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted) &&
      $stable(rsp_granted_index) && $stable(rsp_granted_capacity))
      else $error("result changed while stalled");

   a_deny_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_granted_index == '0 &&
      rsp_granted_capacity == '0)
      else $error("denied result carries nonzero fields");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // load and restart never produce a result transaction
   a_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid && req_command != pfa_pkg::CMD_ALLOC
      |=> !rsp_valid)
      else $error("result without allocate");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == pfa_pkg::CMD_ALLOC |=> !req_ready)
      else $error("ready during allocate scan");

endmodule

bind partition_fit_allocator_core pfa_check u_pfa_check (.*);

`default_nettype wire
